// ===== sv/utf8d_pkg.sv =====
// Shared types and constants for the strict UTF-8 decoder.
// Used by utf8d_step and strict_utf8_decoder; depends on nothing else.
package utf8d_pkg;

  // Widths and depths of the stream fields.
  localparam int ByteW = 8;
  localparam int CodeW = 21;
  localparam int MaxItems = 4;
  localparam int HeldDepth = 3;

  // Kind of a result item.
  localparam logic KIND_CODE = 1'b0;
  localparam logic KIND_STRAY = 1'b1;

  // Byte classes and decode limits.
  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] LEAD2_LOW = 8'hC0;
  localparam logic [7:0] LEAD3_LOW = 8'hE0;
  localparam logic [7:0] LEAD4_LOW = 8'hF0;
  localparam logic [7:0] LEAD_LIMIT = 8'hF8;
  localparam logic [1:0] CONT_TAG = 2'b10;
  localparam logic [CodeW-1:0] MIN_LEN2 = 21'h00080;
  localparam logic [CodeW-1:0] MIN_LEN3 = 21'h00800;
  localparam logic [CodeW-1:0] MIN_LEN4 = 21'h10000;
  localparam logic [CodeW-1:0] SURR_LOW = 21'h0D800;
  localparam logic [CodeW-1:0] SURR_HIGH = 21'h0DFFF;
  localparam logic [CodeW-1:0] CODE_MAX = 21'h10FFFF;

  // Sequence lengths.
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_2 = 3'd2;
  localparam logic [2:0] LEN_3 = 3'd3;
  localparam logic [2:0] LEN_4 = 3'd4;

  // Decoder state carried from byte to byte.
  typedef struct packed {
    logic [HeldDepth-1:0][ByteW-1:0] held;
    logic [1:0]                      count;
    logic [2:0]                      exp_len;
    logic [CodeW-1:0]                partial;
  } dec_state_t;

  // One result item.
  typedef struct packed {
    logic             kind;
    logic [CodeW-1:0] value;
    logic             last;
  } item_t;

  // All results caused by one input byte.
  typedef struct packed {
    item_t [MaxItems-1:0] items;
    logic [2:0]           n;
  } burst_t;

endpackage

// ===== sv/utf8d_step.sv =====
// Combinational decode of one byte against the current sequence state.
// Produces the burst of result items and the next state; uses utf8d_pkg.
module utf8d_step (
  input  logic [7:0]             data_byte,
  input  logic                   end_of_text,
  input  utf8d_pkg::dec_state_t  st,
  output utf8d_pkg::dec_state_t  st_next,
  output utf8d_pkg::burst_t      burst
);

  logic [utf8d_pkg::CodeW-1:0] pc;
  logic [utf8d_pkg::CodeW-1:0] least;
  logic                        ok;

  // Accumulated value with this byte shifted in, and its validity.
  always_comb begin
    pc = {st.partial[utf8d_pkg::CodeW-7:0], data_byte[5:0]};
    case (st.exp_len)
      utf8d_pkg::LEN_2: least = utf8d_pkg::MIN_LEN2;
      utf8d_pkg::LEN_3: least = utf8d_pkg::MIN_LEN3;
      default:          least = utf8d_pkg::MIN_LEN4;
    endcase
    ok = (pc >= least) && !((pc >= utf8d_pkg::SURR_LOW) && (pc <= utf8d_pkg::SURR_HIGH))
         && (pc <= utf8d_pkg::CODE_MAX);
  end

  // Main decision: continue, complete, flush or start afresh.
  always_comb begin
    logic [2:0] k;
    logic       do_fresh;
    logic       do_flush;
    logic [2:0] flush_n;
    st_next = st;
    burst = '0;
    k = 3'd0;
    do_fresh = 1'b0;
    do_flush = 1'b0;
    flush_n = {1'b0, st.count};

    if (st.exp_len == utf8d_pkg::LEN_NONE) begin
      do_fresh = 1'b1;
    end else if (data_byte[7:6] != utf8d_pkg::CONT_TAG) begin
      // A non-continuation byte breaks the sequence.
      do_flush = 1'b1;
      do_fresh = 1'b1;
    end else if ({1'b0, st.count} + 3'd1 >= st.exp_len) begin
      // Final byte of the sequence.
      if (ok) begin
        burst.items[0].kind = utf8d_pkg::KIND_CODE;
        burst.items[0].value = pc;
        k = 3'd1;
        st_next.count = 2'd0;
        st_next.exp_len = utf8d_pkg::LEN_NONE;
        st_next.partial = '0;
      end else begin
        do_flush = 1'b1;
        flush_n = {1'b0, st.count} + 3'd1;
      end
    end else begin
      // Middle byte: hold it; an early end of text flushes everything.
      for (int i = 0; i < utf8d_pkg::HeldDepth; i++) begin
        if (st.count == 2'(i)) begin
          st_next.held[i] = data_byte;
        end
      end
      st_next.count = st.count + 2'd1;
      st_next.partial = pc;
      if (end_of_text) begin
        do_flush = 1'b1;
        flush_n = {1'b0, st.count} + 3'd1;
      end
    end

    // Flush: every held byte (and a failing final byte, or a middle byte at end of text) as its own stray.
    if (do_flush) begin
      for (int i = 0; i < utf8d_pkg::HeldDepth; i++) begin
        if (3'(i) < flush_n) begin
          burst.items[i].kind = utf8d_pkg::KIND_STRAY;
          burst.items[i].value = (3'(i) < {1'b0, st.count}) ?
                                 utf8d_pkg::CodeW'(st.held[i]) :
                                 utf8d_pkg::CodeW'(data_byte);
        end
      end
      if (flush_n == 3'd4) begin
        burst.items[3].kind = utf8d_pkg::KIND_STRAY;
        burst.items[3].value = utf8d_pkg::CodeW'(data_byte);
      end
      k = flush_n;
      st_next.count = 2'd0;
      st_next.exp_len = utf8d_pkg::LEN_NONE;
      st_next.partial = '0;
    end

    // Decode the byte as if no sequence were open.
    if (do_fresh) begin
      if (data_byte < utf8d_pkg::ASCII_LIMIT) begin
        burst.items[k[1:0]].kind = utf8d_pkg::KIND_CODE;
        burst.items[k[1:0]].value = utf8d_pkg::CodeW'(data_byte);
        k = k + 3'd1;
      end else if (data_byte < utf8d_pkg::LEAD2_LOW || data_byte >= utf8d_pkg::LEAD_LIMIT
                   || end_of_text) begin
        burst.items[k[1:0]].kind = utf8d_pkg::KIND_STRAY;
        burst.items[k[1:0]].value = utf8d_pkg::CodeW'(data_byte);
        k = k + 3'd1;
      end else begin
        st_next.held[0] = data_byte;
        st_next.count = 2'd1;
        if (data_byte < utf8d_pkg::LEAD3_LOW) begin
          st_next.exp_len = utf8d_pkg::LEN_2;
          st_next.partial = utf8d_pkg::CodeW'(data_byte[4:0]);
        end else if (data_byte < utf8d_pkg::LEAD4_LOW) begin
          st_next.exp_len = utf8d_pkg::LEN_3;
          st_next.partial = utf8d_pkg::CodeW'(data_byte[3:0]);
        end else begin
          st_next.exp_len = utf8d_pkg::LEN_4;
          st_next.partial = utf8d_pkg::CodeW'(data_byte[2:0]);
        end
      end
    end

    // Mark the final result of this byte.
    if (k != 3'd0) begin
      burst.items[2'(k - 3'd1)].last = 1'b1;
    end
    burst.n = k;
  end

endmodule

// ===== sv/strict_utf8_decoder.sv =====
// Top level of the strict UTF-8 decoder: input register, decode step, result buffer.
// Depends on utf8d_pkg and utf8d_step.
//
//  Channel | Dir | tdata                  | tuser     | tlast
//  s_*     | in  | [7:0] data_byte        | -         | end_of_text
//  m_*     | out | [20:0] code_value, pad | item_kind | last_of_run
//
// One byte a cycle is accepted while each byte yields at most one result and m_tready is high.
// A byte that yields several results holds the input while the four-entry result
// buffer drains one result a cycle while m_tready is high; the next byte is taken as its last result leaves.
// A request passes through the input register and then the result buffer to its first result.
// rst is synchronous and clears the sequence state (but not the held bytes) and both valid flags.
// A stall on m_tready backs up through the buffer to s_tready.
module strict_utf8_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [20:0] code_value, [23:21] zero
  output logic        m_tuser,   // [0] item_kind
  output logic        m_tlast
);

  // Input register.
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eot;

  // Decoder state and step outputs.
  utf8d_pkg::dec_state_t st;
  utf8d_pkg::dec_state_t st_next;
  utf8d_pkg::burst_t     burst;

  // Result buffer.
  utf8d_pkg::item_t buf_items [utf8d_pkg::MaxItems];
  logic [1:0]       rd;
  logic [2:0]       cnt;

  logic pop;
  logic fire;

  assign pop = m_tvalid && m_tready;
  assign fire = in_valid && ((cnt == 3'd0) || ((cnt == 3'd1) && pop));
  assign s_tready = !in_valid || fire;

  utf8d_step u_step (
    .data_byte   (in_byte),
    .end_of_text (in_eot),
    .st          (st),
    .st_next     (st_next),
    .burst       (burst)
  );

  // Input register takes a request whenever it is empty or the held byte moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_eot <= s_tlast;
    end
  end

  // Sequence state advances once per decoded byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.count <= 2'd0;
      st.exp_len <= utf8d_pkg::LEN_NONE;
      st.partial <= '0;
    end else if (fire) begin
      st.count <= st_next.count;
      st.exp_len <= st_next.exp_len;
      st.partial <= st_next.partial;
    end
    if (fire) begin
      st.held <= st_next.held;
    end
  end

  // Result buffer: load a whole burst, then hand out one result a cycle while m_tready is high.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
      rd <= 2'd0;
    end else if (fire && (burst.n != 3'd0)) begin
      cnt <= burst.n;
      rd <= 2'd0;
    end else if (pop) begin
      cnt <= cnt - 3'd1;
      rd <= rd + 2'd1;
    end
    if (fire && (burst.n != 3'd0)) begin
      for (int i = 0; i < utf8d_pkg::MaxItems; i++) begin
        buf_items[i] <= burst.items[i];
      end
    end
  end

  assign m_tvalid = (cnt != 3'd0);
  assign m_tdata = {3'b000, buf_items[rd].value};
  assign m_tuser = buf_items[rd].kind;
  assign m_tlast = buf_items[rd].last;

`ifndef NO_ASSERTIONS
  // The buffer never holds more than one burst.
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt <= 3'd4)
    else $error("result buffer count out of range");

  // Only the last buffered result of a burst closes the run.
  a_last_marks: assert property (@(posedge clk) disable iff (rst)
    (cnt == 3'd1) |-> m_tlast)
    else $error("final buffered result lacks last_of_run");

  a_last_early: assert property (@(posedge clk) disable iff (rst)
    (cnt > 3'd1) |-> !m_tlast)
    else $error("last_of_run set before the end of a burst");

  // Held count and sequence length stay consistent.
  a_closed_empty: assert property (@(posedge clk) disable iff (rst)
    (st.exp_len == utf8d_pkg::LEN_NONE) |-> (st.count == 2'd0))
    else $error("bytes held with no open sequence");

  a_open_held: assert property (@(posedge clk) disable iff (rst)
    (st.exp_len != utf8d_pkg::LEN_NONE) |->
      ((st.count != 2'd0) && ({1'b0, st.count} < st.exp_len)))
    else $error("open sequence holds a bad byte count");
`endif

endmodule
